FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/i8gta_pkg.sv
package i8gta_pkg;

  localparam int TILE_ROWS  = 8;
  localparam int TILE_COLS  = 8;
  localparam int ACC_W      = 32;
  localparam int ROW_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int COL_W      = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int ROW_DATA_W = TILE_COLS * ACC_W;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request fields
    logic rd_acc;  // read accumulator row at the sweep counter
    logic wr_acc;  // write updated row, advance the sweep counter
    logic rd_upd;  // read the row holding the selected element
    logic mul;     // register scale times selected accumulator
    logic emit;    // form c_new and raise done
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_row;
  } status_t;

  // signed byte of a packed lane word, lanes past eight read as zero
  function automatic logic signed [7:0] lane_byte(input logic [63:0] word,
                                                  input int unsigned idx);
    logic signed [7:0] b;
    b = '0;
    if (idx < 8) b = word[8*idx[2:0] +: 8];
    return b;
  endfunction

endpackage

FILE: hw/rtl/int8_gemm_tile_accumulator.sv
// int8 gemm tile engine: 8x8 signed byte outer products into int32 accumulators
// request channel: start with op and its fields, taken on a rising edge while busy
//   is low; busy stays high until the controller is back in idle
// op 0 (k-step): a_lanes/b_lanes hold eight signed bytes each; first_k clears the
//   tile first; busy while each accumulator ram row in turn is read (ACC_RD) and
//   written back (ACC_WR), no result
// op 1 (update): row_sel/col_sel/c_old; c_new = c_old + scale * acc, wrapped at
//   32 bits; busy through the ram read, 32x32 multiply and add (UPD_RD, UPD_MUL,
//   UPD_ADD), after which done is high for one cycle with c_new valid
// a new request is taken only back in idle, once the previous one has run through
//   the registered-read accumulator row ram and the sweep sequencer
// config: cfg_we/cfg_wdata write scale; the user must write it only while idle, unchecked by the block; no read-back
// reset (rst, synchronous): scale returns to 1 and every accumulator row is
//   marked clear through per-row valid bits, no clearing pass needed
// results cannot be held off: done and c_new are registered and shown once
module int8_gemm_tile_accumulator
  import i8gta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic               first_k,
  input  logic [63:0]        a_lanes,
  input  logic [63:0]        b_lanes,
  input  logic [2:0]         row_sel,
  input  logic [2:0]         col_sel,
  input  logic signed [31:0] c_old,
  output logic               done,
  output logic signed [31:0] c_new,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata
);

`include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  // sequencer: sweeps rows for a k-step, three steps for an update
  i8gta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  // request registers, accumulator ram, byte multipliers and alpha path
  i8gta_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .op       (op),
    .first_k  (first_k),
    .a_lanes  (a_lanes),
    .b_lanes  (b_lanes),
    .row_sel  (row_sel),
    .col_sel  (col_sel),
    .c_old    (c_old),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .c_new    (c_new)
  );

  // done follows an update request once its read, multiply and add states are through
  `ASSERT_CLK(a_upd_latency, clk, rst, (start && !busy && op) |-> ##4 done)
  // a k-step never produces a result right after it is taken
  `ASSERT_NEXT(a_kstep_quiet, clk, rst, start && !busy && !op, !done)
  // busy only rises after a request was taken
  `ASSERT_CLK(a_busy_cause, clk, rst, $rose(busy) |-> $past(start))

endmodule

FILE: hw/rtl/i8gta_ram.sv
module i8gta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/i8gta_ctrl.sv
module i8gta_ctrl
  import i8gta_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    op,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ACC_RD  = 6'b000010,
    ST_ACC_WR  = 6'b000100,
    ST_UPD_RD  = 6'b001000,
    ST_UPD_MUL = 6'b010000,
    ST_UPD_ADD = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = op ? ST_UPD_RD : ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        cmd.rd_acc = 1'b1;
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.wr_acc = 1'b1;
        state_next = status.last_row ? ST_IDLE : ST_ACC_RD;
      end
      ST_UPD_RD: begin
        cmd.rd_upd = 1'b1;
        state_next = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD_ADD;
      end
      ST_UPD_ADD: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: hw/rtl/i8gta_dpath.sv
module i8gta_dpath
  import i8gta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               op,
  input  logic               first_k,
  input  logic [63:0]        a_lanes,
  input  logic [63:0]        b_lanes,
  input  logic [2:0]         row_sel,
  input  logic [2:0]         col_sel,
  input  logic signed [31:0] c_old,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata,
  output logic               done,
  output logic signed [31:0] c_new
);

  logic [31:0]            scale;
  logic [63:0]            a_q, b_q;
  logic [2:0]             row_sel_q, col_sel_q;
  logic [31:0]            c_old_q;
  logic [ROW_W-1:0]       row_cnt;
  logic [TILE_ROWS-1:0]   row_valid;
  logic [31:0]            prod;

  logic [ROW_W+2:0]       row_ext;
  logic [COL_W+2:0]       col_ext;
  logic [ROW_W-1:0]       upd_row, rd_addr;
  logic [COL_W-1:0]       upd_col;
  logic                   sel_ok;
  logic [ROW_DATA_W-1:0]  rd_data, wr_data;
  logic [ACC_W-1:0]       acc_old [TILE_COLS];
  logic signed [15:0]     prod8 [TILE_COLS];
  logic signed [7:0]      a_sel;
  logic [ACC_W-1:0]       acc_pick;

  always_ff @(posedge clk) begin
    if (rst) scale <= 32'd1;
    else if (cfg_we) scale <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_q       <= a_lanes;
      b_q       <= b_lanes;
      row_sel_q <= row_sel;
      col_sel_q <= col_sel;
      c_old_q   <= c_old;
    end
    if (cmd.mul) prod <= scale * acc_pick;
    if (cmd.emit) c_new <= c_old_q + prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.load) begin
        row_cnt <= '0;
        if (!op && first_k) row_valid <= '0;
      end else if (cmd.wr_acc) begin
        row_cnt            <= row_cnt + 1'b1;
        row_valid[row_cnt] <= 1'b1;
      end
    end
  end

  assign status.last_row = (row_cnt == ROW_W'(TILE_ROWS - 1));

  // selected element, out-of-tile selectors read as zero
  assign row_ext = (ROW_W+3)'(row_sel_q);
  assign col_ext = (COL_W+3)'(col_sel_q);
  assign upd_row = row_ext[ROW_W-1:0];
  assign upd_col = col_ext[COL_W-1:0];
  assign sel_ok  = (32'(row_sel_q) < TILE_ROWS) && (32'(col_sel_q) < TILE_COLS);
  assign rd_addr = cmd.rd_acc ? row_cnt : upd_row;

  always_comb begin
    acc_pick = '0;
    if (sel_ok && row_valid[upd_row]) acc_pick = rd_data[upd_col*ACC_W +: ACC_W];
  end

  // one row of the outer product per write
  always_comb begin
    a_sel = lane_byte(a_q, 32'(row_cnt));
    for (int c = 0; c < TILE_COLS; c++) begin
      acc_old[c] = row_valid[row_cnt] ? rd_data[c*ACC_W +: ACC_W] : '0;
      prod8[c]   = a_sel * lane_byte(b_q, c);
      wr_data[c*ACC_W +: ACC_W] = acc_old[c] + {{(ACC_W-16){prod8[c][15]}}, prod8[c]};
    end
  end

  i8gta_ram #(
    .WIDTH(ROW_DATA_W),
    .DEPTH(TILE_ROWS)
  ) u_acc_ram (
    .clk  (clk),
    .we   (cmd.wr_acc),
    .waddr(row_cnt),
    .wdata(wr_data),
    .re   (cmd.rd_acc | cmd.rd_upd),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

endmodule

FILE: test/tb_int8_gemm_tile_accumulator.sv
`timescale 1ns / 1ps

module tb_int8_gemm_tile_accumulator;
  import i8gta_pkg::*;

  // request codes carried on op
  localparam logic OP_KSTEP  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // cycles with no request taken, no result and no scale write before the run is abandoned
  localparam int STALL_LIMIT  = 2000;
  // cycles left after the last c_new before touching scale or ending
  localparam int SETTLE_CYCLES = 8;
  // requests per scale setting in the random part, at least
  localparam int PHASE_ITEMS  = 290;
  localparam int PHASE_COUNT  = 5;

  // every input known from time zero, reset held from the start
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = OP_KSTEP;
  logic               first_k = 1'b0;
  logic [63:0]        a_lanes = '0;
  logic [63:0]        b_lanes = '0;
  logic [2:0]         row_sel = '0;
  logic [2:0]         col_sel = '0;
  logic signed [31:0] c_old = '0;
  logic               done;
  logic signed [31:0] c_new;
  logic               cfg_we = 1'b0;
  logic signed [31:0] cfg_wdata = '0;

  int8_gemm_tile_accumulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .first_k   (first_k),
    .a_lanes   (a_lanes),
    .b_lanes   (b_lanes),
    .row_sel   (row_sel),
    .col_sel   (col_sel),
    .c_old     (c_old),
    .done      (done),
    .c_new     (c_new),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // tile predictor: own copy of the accumulators and of alpha
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] tile_sum [TILE_ROWS][TILE_COLS];
  logic [31:0]      alpha;

  // c_new values owed by the block, oldest first
  logic [31:0] c_new_owed [$];

  int fail_count;
  int kstep_count;
  int update_count;
  int checked_count;
  int scale_writes;
  bit quiet_sender;   // phase without sender gaps

  function automatic void clear_tile();
    for (int r = 0; r < TILE_ROWS; r++)
      for (int c = 0; c < TILE_COLS; c++)
        tile_sum[r][c] = '0;
  endfunction

  // outer product of one k-step added into the tile, wrapping at 32 bits
  function automatic void add_outer_product(input logic fk, input logic [63:0] a,
                                            input logic [63:0] b);
    int a_val;
    int b_val;
    if (fk) clear_tile();
    for (int r = 0; r < TILE_ROWS; r++) begin
      // lanes past eight carry zero
      a_val = (r < 8) ? int'($signed(a[8*r +: 8])) : 0;
      for (int c = 0; c < TILE_COLS; c++) begin
        b_val = (c < 8) ? int'($signed(b[8*c +: 8])) : 0;
        tile_sum[r][c] += a_val * b_val;
      end
    end
  endfunction

  // c_old + alpha * accumulator, low 32 bits kept
  function automatic logic [31:0] scaled_update(input logic [2:0] r, input logic [2:0] c,
                                                input logic [31:0] co);
    logic [31:0] acc;
    acc = '0;
    if (r < TILE_ROWS && c < TILE_COLS) acc = tile_sum[r][c];
    return co + alpha * acc;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: fields change on the falling edge, acceptance seen on rising
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op_i, input logic fk_i,
                              input logic [63:0] a_i, input logic [63:0] b_i,
                              input logic [2:0] row_i, input logic [2:0] col_i,
                              input logic [31:0] co_i);
    // random gaps, each drawn with a chance of 17 in 100
    while (!quiet_sender && $urandom_range(99) < 17) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    op      <= op_i;
    first_k <= fk_i;
    a_lanes <= a_i;
    b_lanes <= b_i;
    row_sel <= row_i;
    col_sel <= col_i;
    c_old   <= co_i;
    // start stays high until the block takes the request
    do @(posedge clk); while (busy);
    if (op_i == OP_KSTEP) begin
      add_outer_product(fk_i, a_i, b_i);
      kstep_count++;
    end else begin
      c_new_owed.push_back(scaled_update(row_i, col_i, co_i));
      update_count++;
    end
  endtask

  task automatic send_kstep(input logic fk, input logic [63:0] a, input logic [63:0] b);
    // selectors and c_old are don't-care here, so fill them with noise
    send_request(OP_KSTEP, fk, a, b, 3'($urandom), 3'($urandom), $urandom);
  endtask

  task automatic send_update(input logic [2:0] r, input logic [2:0] c, input logic [31:0] co);
    // lanes and first_k are don't-care on an update
    send_request(OP_UPDATE, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                 r, c, co);
  endtask

  // wait until the block is idle and every owed c_new has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (busy || c_new_owed.size() != 0);
    // the block is idle and nothing is owed by now; a margin is still allowed
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // scale is only written while idle
  task automatic write_scale(input logic [31:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    alpha = value;
    scale_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // byte lanes biased towards the corners of the int8 range
  function automatic logic [63:0] pick_lanes();
    logic [63:0] w;
    logic [7:0]  corner [5];
    corner = '{8'h80, 8'h7f, 8'hff, 8'h00, 8'h01};
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(99) < 20) w[8*i +: 8] = corner[$urandom_range(4)];
      else w[8*i +: 8] = 8'($urandom);
    end
    return w;
  endfunction

  function automatic logic [31:0] pick_c_old();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: c_new is shown for one cycle and cannot be held off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [31:0] owed;
    if (!rst && done) begin
      if (c_new_owed.size() == 0) begin
        $error("c_new: no result expected, actual %0d", c_new);
        fail_count++;
      end else begin
        owed = c_new_owed.pop_front();
        checked_count++;
        if (c_new !== owed) begin
          $error("c_new: expected %0d, actual %0d", $signed(owed), c_new);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    int quiet_cycles;
    if ((start && !busy) || done || cfg_we || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("int8_gemm_tile_accumulator: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // straight after reset every accumulator reads zero, so c_new equals c_old
  task automatic test_cleared_tile();
    send_update(3'd0, 3'd0, 32'h8000_0000);
    send_update(3'd7, 3'd7, 32'h7fff_ffff);
    send_update(3'd3, 3'd5, 32'hffff_ffff);
    send_update(3'd6, 3'd1, $urandom);
  endtask

  // int8 corners in the lanes, first_k clear, plain accumulate, and a zero clear
  task automatic test_byte_corners();
    send_kstep(1'b1, 64'h557f_8000_01ff_7f80, 64'h8001_ff7f_0080_557f);
    send_kstep(1'b0, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
    send_update(3'd0, 3'd0, 32'h0000_0000);
    send_update(3'd7, 3'd7, 32'h7fff_ffff);
    send_update(3'd1, 3'd0, 32'h8000_0000);
    send_update(3'd0, 3'd1, 32'hffff_ffff);
    send_kstep(1'b0, 64'h7f7f_7f7f_7f7f_7f7f, 64'h8080_8080_8080_8080);
    send_update(3'd4, 3'd2, 32'h0000_0001);
    // first_k with all-zero lanes leaves a cleared tile
    send_kstep(1'b1, 64'h0, 64'h0);
    send_update(3'd5, 3'd6, 32'h1234_5678);
  endtask

  // alpha at its extremes, with results wrapping at 32 bits
  task automatic test_scale_extremes();
    logic [31:0] corner_scale [4];
    corner_scale = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    send_kstep(1'b1, 64'h8080_8080_8080_8080, 64'h807f_8001_ff80_7f80);
    foreach (corner_scale[i]) begin
      write_scale(corner_scale[i]);
      send_update(3'(i), 3'(7 - i), 32'h7fff_ffff);
      send_update(3'(7 - i), 3'(i), 32'h8000_0000);
    end
  endtask

  // ---------------------------------------------------------------------------
  // random tiles: mostly well-formed k-loops, then element updates, plus noise
  // ---------------------------------------------------------------------------
  task automatic test_random_tiles();
    logic [31:0] phase_scale [PHASE_COUNT];
    int sent;
    int k_steps;
    int reads;
    phase_scale = '{$urandom, 32'h0000_0001, 32'hffff_ffff, $urandom_range(255), $urandom};
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_scale(phase_scale[p]);
      // the middle phase runs the sender flat out
      quiet_sender = (p == PHASE_COUNT / 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 10) begin
          // stray request, any op with any fields
          send_request(1'($urandom), 1'($urandom), {$urandom, $urandom},
                       {$urandom, $urandom}, 3'($urandom), 3'($urandom), $urandom);
          sent++;
        end else begin
          k_steps = $urandom_range(6);
          reads   = $urandom_range(1, 8);
          send_kstep(1'b1, pick_lanes(), pick_lanes());
          repeat (k_steps) send_kstep(1'b0, pick_lanes(), pick_lanes());
          repeat (reads) send_update(3'($urandom), 3'($urandom), pick_c_old());
          sent += 1 + k_steps + reads;
        end
      end
      quiet_sender = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count    = 0;
    kstep_count   = 0;
    update_count  = 0;
    checked_count = 0;
    scale_writes  = 0;
    quiet_sender  = 1'b0;
    // model starts from the reset state: alpha of one, cleared tile
    alpha = 32'd1;
    clear_tile();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_cleared_tile();
    test_byte_corners();
    test_scale_extremes();
    test_random_tiles();

    drain();

    $display("covered %0d k-steps and %0d element updates under %0d scale writes",
             kstep_count, update_count, scale_writes);
    $display("%0d c_new results checked, including int8 and alpha corners", checked_count);
    if (fail_count == 0) begin
      $display("int8_gemm_tile_accumulator: match");
    end else begin
      $display("int8_gemm_tile_accumulator: mismatch");
    end
    $finish;
  end

endmodule
